>>> design/rrt_pkg.sv
// rrt_pkg.sv: types and codes shared by the request reassembly tracker
`timescale 1ns / 1ps
package rrt_pkg;

  localparam int unsigned KeyW = 40;
  localparam int unsigned PktW = 17;
  localparam logic [PktW-1:0] PktMax = '1;

  typedef enum logic [1:0] {
    OP_PKT   = 2'd0,
    OP_REPLY = 2'd1,
    OP_SWEEP = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_DUP     = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] node_addr;
    logic [7:0]  client_thread;
    logic [15:0] req_id;
    logic        is_first;
    logic [15:0] packet_index;
    logic [15:0] payload_bytes;
  } in_t;

  typedef struct packed {
    logic        deliver;
    logic [15:0] out_node_addr;
    logic [7:0]  out_client_thread;
    logic [15:0] out_req_id;
    logic [31:0] total_bytes;
    logic [6:0]  freed_count;
    logic [1:0]  status;
  } out_t;

  typedef struct packed {
    op_e             kind;
    logic [KeyW-1:0] key;
    logic            is_first;
    logic [PktW-1:0] expected;
    logic [15:0]     payload_bytes;
  } cmd_t;

  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] key;
    logic            known;
    logic [PktW-1:0] expected;
    logic [PktW-1:0] received;
    logic [31:0]     bytes;
    logic            reply;
    logic            aged;
  } rec_t;

endpackage

>>> design/request_reassembly_tracker.sv
// request_reassembly_tracker.sv: top level of the request reassembly tracker
//
//   channel  | handshake          | payload
//   ---------+--------------------+---------------------------
//   input    | push / full        | in_i  (rrt_pkg::in_t)
//   result   | empty / pop        | out_o (rrt_pkg::out_t)
//
// packet and reply items scan one entry at a time (read, then check) until the first match;
// the result waits in a result register and moves to out_o once out_o is empty or being popped
// sweeps always scan every entry, an unused opcode skips the scan
// after reset a clearing pass over every table entry holds full high
// the two-deep front queue keeps taking items while a result waits for pop
`timescale 1ns / 1ps
module request_reassembly_tracker #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  rrt_pkg::in_t  in_i,
  output logic          empty,
  input  logic          pop,
  output rrt_pkg::out_t out_o
);
  import rrt_pkg::*;

  logic cmd_valid, cmd_take, clearing, res_valid;
  cmd_t cmd;

  rrt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .in_i        (in_i),
    .hold_i      (clearing),
    .full_o      (full),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  rrt_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .clearing_o  (clearing),
    .res_valid_o (res_valid),
    .res_o       (out_o),
    .pop_i       (pop)
  );

  assign empty = !res_valid;

endmodule

>>> design/rrt_front.sv
// rrt_front.sv: input acceptance, command decode and a two-deep command queue
`timescale 1ns / 1ps
module rrt_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rrt_pkg::in_t  in_i,
  input  logic          hold_i,
  output logic          full_o,
  output logic          cmd_valid_o,
  output rrt_pkg::cmd_t cmd_o,
  input  logic          cmd_take_i
);
  import rrt_pkg::*;

  cmd_t       q_mem [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  cmd_t       cmd_new;
  logic       wr, rd;

  always_comb begin
    cmd_new.kind          = op_e'(in_i.opcode);
    cmd_new.key           = {in_i.node_addr, in_i.client_thread, in_i.req_id};
    cmd_new.is_first      = in_i.is_first;
    cmd_new.expected      = {1'b0, in_i.packet_index} + PktW'(1);
    cmd_new.payload_bytes = in_i.payload_bytes;
  end

  assign full_o      = hold_i || (cnt_q == 2'd2);
  assign wr          = push_i && !full_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign rd          = cmd_take_i && cmd_valid_o;
  assign cmd_o       = q_mem[rptr_q];

  always_comb begin
    wptr_d = wr ? ~wptr_q : wptr_q;
    rptr_d = rd ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, wr} - {1'b0, rd};
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      q_mem[wptr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

>>> design/rrt_back.sv
// rrt_back.sv: entry table, lookup and sweep engine, result register
`timescale 1ns / 1ps
module rrt_back #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  rrt_pkg::cmd_t cmd_i,
  output logic          cmd_take_o,
  output logic          clearing_o,
  output logic          res_valid_o,
  output rrt_pkg::out_t res_o,
  input  logic          pop_i
);
  import rrt_pkg::*;

  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IW:0] Last = (IW+1)'(TABLE_ENTRIES - 1);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_RD    = 6'b000100,
    S_CHK   = 6'b001000,
    S_UPD   = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  state_e          state_q, state_d;
  rec_t            mem [TABLE_ENTRIES];
  rec_t            rdata_q, wdata;
  logic            we, re;
  logic [IW-1:0]   waddr;
  logic [IW:0]     cnt_q, cnt_d;
  cmd_t            cmd_q, cmd_d;
  logic            hit_q, hit_d, free_q, free_d;
  logic [IW-1:0]   hit_idx_q, hit_idx_d, free_idx_q, free_idx_d;
  rec_t            hit_rec_q, hit_rec_d;
  logic [6:0]      freed_q, freed_d;
  out_t            res_q, res_d, out_q, out_d;
  logic            out_valid_q, out_valid_d;
  logic [PktW-1:0] rcv_n, exp_n;
  logic            known_n;
  logic [32:0]     bsum;
  logic [31:0]     bytes_n;

  assign cmd_take_o  = (state_q == S_IDLE) && cmd_valid_i;
  assign clearing_o  = (state_q == S_CLEAR);
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;
  assign re          = (state_q == S_RD);

  always_comb begin
    rcv_n   = (hit_rec_q.received == PktMax) ? hit_rec_q.received
                                             : hit_rec_q.received + PktW'(1);
    bsum    = {1'b0, hit_rec_q.bytes} + {17'd0, cmd_q.payload_bytes};
    bytes_n = bsum[32] ? 32'hFFFF_FFFF : bsum[31:0];
    known_n = hit_rec_q.known || cmd_q.is_first;
    exp_n   = cmd_q.is_first ? cmd_q.expected : hit_rec_q.expected;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_d       = cmd_q;
    hit_d       = hit_q;
    free_d      = free_q;
    hit_idx_d   = hit_idx_q;
    free_idx_d  = free_idx_q;
    hit_rec_d   = hit_rec_q;
    freed_d     = freed_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    we          = 1'b0;
    waddr       = cnt_q[IW-1:0];
    wdata       = rdata_q;
    if (out_valid_q && pop_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_CLEAR: begin
        we          = 1'b1;
        wdata       = '0;
        cnt_d       = cnt_q + (IW+1)'(1);
        if (cnt_q == Last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d   = cmd_i;
          cnt_d   = '0;
          hit_d   = 1'b0;
          free_d  = 1'b0;
          freed_d = '0;
          res_d   = '0;
          state_d = (cmd_i.kind == OP_NONE) ? S_OUT : S_RD;
        end
      end
      S_RD: begin
        state_d = S_CHK;
      end
      S_CHK: begin
        if (cmd_q.kind == OP_SWEEP) begin
          if (rdata_q.valid && rdata_q.reply) begin
            we = 1'b1;
            if (rdata_q.aged) begin
              wdata.valid = 1'b0;
              if (freed_q != 7'd127) begin
                freed_d = freed_q + 7'd1;
              end
            end else begin
              wdata.aged = 1'b1;
            end
          end
          if (cnt_q == Last) begin
            res_d.freed_count = freed_d;
            state_d = S_OUT;
          end else begin
            cnt_d   = cnt_q + (IW+1)'(1);
            state_d = S_RD;
          end
        end else begin
          if (rdata_q.valid && rdata_q.key == cmd_q.key) begin
            hit_d     = 1'b1;
            hit_idx_d = cnt_q[IW-1:0];
            hit_rec_d = rdata_q;
            state_d   = S_UPD;
          end else begin
            if (!rdata_q.valid && !free_q) begin
              free_d     = 1'b1;
              free_idx_d = cnt_q[IW-1:0];
            end
            if (cnt_q == Last) begin
              state_d = S_UPD;
            end else begin
              cnt_d   = cnt_q + (IW+1)'(1);
              state_d = S_RD;
            end
          end
        end
      end
      S_UPD: begin
        res_d.out_node_addr     = cmd_q.key[39:24];
        res_d.out_client_thread = cmd_q.key[23:16];
        res_d.out_req_id        = cmd_q.key[15:0];
        state_d = S_OUT;
        if (cmd_q.kind == OP_REPLY) begin
          if (hit_q) begin
            we                = 1'b1;
            waddr             = hit_idx_q;
            wdata             = hit_rec_q;
            wdata.reply       = 1'b1;
            res_d.total_bytes = hit_rec_q.bytes;
          end else begin
            res_d.status = ST_UNKNOWN;
          end
        end else if (hit_q) begin
          if (cmd_q.is_first && hit_rec_q.known) begin
            res_d.total_bytes = hit_rec_q.bytes;
            res_d.status      = ST_DUP;
          end else begin
            we                = 1'b1;
            waddr             = hit_idx_q;
            wdata             = hit_rec_q;
            wdata.received    = rcv_n;
            wdata.bytes       = bytes_n;
            wdata.known       = known_n;
            wdata.expected    = exp_n;
            res_d.total_bytes = bytes_n;
            res_d.deliver     = known_n && (exp_n == rcv_n);
          end
        end else if (free_q) begin
          we                = 1'b1;
          waddr             = free_idx_q;
          wdata.valid       = 1'b1;
          wdata.key         = cmd_q.key;
          wdata.known       = cmd_q.is_first;
          wdata.expected    = cmd_q.is_first ? cmd_q.expected : '0;
          wdata.received    = PktW'(1);
          wdata.bytes       = {16'd0, cmd_q.payload_bytes};
          wdata.reply       = 1'b0;
          wdata.aged        = 1'b0;
          res_d.total_bytes = {16'd0, cmd_q.payload_bytes};
          res_d.deliver     = cmd_q.is_first && (cmd_q.expected == PktW'(1));
        end else begin
          res_d.status = ST_FULL;
        end
      end
      S_OUT: begin
        if (!out_valid_q || pop_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[cnt_q[IW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    hit_rec_q  <= hit_rec_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      freed_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      hit_q       <= hit_d;
      free_q      <= free_d;
      freed_q     <= freed_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_deliver_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.deliver |-> out_q.status == ST_OK)
    else $error("delivery with error status");

  a_freed_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.freed_count != 7'd0 |->
      !out_q.deliver && out_q.out_req_id == 16'd0 && out_q.total_bytes == 32'd0)
    else $error("freed count on a non-sweep result");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !out_valid_q && !cmd_take_o)
    else $error("activity during clearing pass");

endmodule

>>> test/request_reassembly_tracker_tb.sv
// request_reassembly_tracker_tb.sv: self-checking testbench for the request reassembly tracker
`timescale 1ns / 1ps
module request_reassembly_tracker_tb;
  import rrt_pkg::*;

  localparam int unsigned Entries = 64;
  localparam int unsigned NumRandom = 2000;
  localparam longint CycleLimit = 3000000;

  logic clk_i;
  logic rst_ni;
  logic push;
  logic full;
  in_t in_i;
  logic empty;
  logic pop;
  out_t out_o;

  request_reassembly_tracker #(.TABLE_ENTRIES(Entries)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full), .in_i(in_i),
    .empty(empty), .pop(pop), .out_o(out_o)
  );

  typedef struct {
    in_t  item;
    logic has_fixed;
    out_t fixed;
  } row_t;

  rec_t trk_table [Entries];
  out_t outcome_q[$];
  int unsigned mismatches;
  longint cycles;
  logic stim_done;
  logic [15:0] key_addr [8];
  logic [7:0]  key_thr [8];
  logic [15:0] key_rid [8];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic out_t track_item(in_t it);
    out_t r;
    logic [KeyW-1:0] k;
    int e;
    int unsigned freed;
    logic [32:0] sum;
    r = '0;
    k = {it.node_addr, it.client_thread, it.req_id};
    e = -1;
    if (it.opcode == OP_PKT || it.opcode == OP_REPLY) begin
      r.out_node_addr = it.node_addr;
      r.out_client_thread = it.client_thread;
      r.out_req_id = it.req_id;
      for (int i = 0; i < Entries; i++)
        if (e < 0 && trk_table[i].valid && trk_table[i].key == k) e = i;
    end
    if (it.opcode == OP_PKT) begin
      if (e < 0) begin
        for (int i = 0; i < Entries; i++)
          if (e < 0 && !trk_table[i].valid) e = i;
        if (e < 0) begin
          r.status = ST_FULL;
          return r;
        end
        trk_table[e].valid = 1'b1;
        trk_table[e].key = k;
        trk_table[e].known = it.is_first;
        trk_table[e].expected = it.is_first ? {1'b0, it.packet_index} + 17'd1 : '0;
        trk_table[e].received = 17'd1;
        trk_table[e].bytes = {16'd0, it.payload_bytes};
        trk_table[e].reply = 1'b0;
        trk_table[e].aged = 1'b0;
      end else begin
        if (it.is_first && trk_table[e].known) begin
          r.total_bytes = trk_table[e].bytes;
          r.status = ST_DUP;
          return r;
        end
        if (trk_table[e].received != PktMax) trk_table[e].received++;
        sum = {1'b0, trk_table[e].bytes} + {17'd0, it.payload_bytes};
        trk_table[e].bytes = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        if (it.is_first) begin
          trk_table[e].known = 1'b1;
          trk_table[e].expected = {1'b0, it.packet_index} + 17'd1;
        end
      end
      r.total_bytes = trk_table[e].bytes;
      r.deliver = trk_table[e].known && trk_table[e].expected == trk_table[e].received;
    end else if (it.opcode == OP_REPLY) begin
      if (e < 0) r.status = ST_UNKNOWN;
      else begin
        trk_table[e].reply = 1'b1;
        r.total_bytes = trk_table[e].bytes;
      end
    end else if (it.opcode == OP_SWEEP) begin
      freed = 0;
      for (int i = 0; i < Entries; i++) begin
        if (trk_table[i].valid && trk_table[i].reply) begin
          if (trk_table[i].aged) begin
            trk_table[i].valid = 1'b0;
            if (freed < 127) freed++;
          end else trk_table[i].aged = 1'b1;
        end
      end
      r.freed_count = freed[6:0];
    end
    return r;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic in_t mk(logic [1:0] op, logic [15:0] a, logic [7:0] t, logic [15:0] r,
                             logic f, logic [15:0] idx, logic [15:0] pay);
    in_t x;
    x.opcode = op;
    x.node_addr = a;
    x.client_thread = t;
    x.req_id = r;
    x.is_first = f;
    x.packet_index = idx;
    x.payload_bytes = pay;
    return x;
  endfunction

  function automatic out_t res(logic d, in_t x, logic [31:0] tb, logic [1:0] st);
    out_t o;
    o = '0;
    o.deliver = d;
    o.out_node_addr = x.node_addr;
    o.out_client_thread = x.client_thread;
    o.out_req_id = x.req_id;
    o.total_bytes = tb;
    o.status = st;
    return o;
  endfunction

  task automatic send(in_t it, logic has_fixed, out_t fixed);
    out_t p;
    int unsigned n;
    n = gap_len();
    if (n != 0) begin
      push <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
    push <= 1'b1;
    in_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    p = track_item(it);
    outcome_q.insert(outcome_q.size(), has_fixed ? fixed : p);
    @(negedge clk_i);
  endtask

  function automatic in_t random_item();
    in_t x;
    int unsigned p;
    int k;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    x = raw[$bits(in_t)-1:0];
    p = $urandom_range(0, 99);
    k = $urandom_range(0, 7);
    if (p < 80) begin
      x.node_addr = key_addr[k];
      x.client_thread = key_thr[k];
      x.req_id = key_rid[k];
      x.packet_index = 16'($urandom_range(0, 5));
      x.payload_bytes = ($urandom_range(0, 9) == 0) ? 16'hFFFF : x.payload_bytes;
    end
    p = $urandom_range(0, 99);
    x.opcode = p < 70 ? OP_PKT : p < 84 ? OP_REPLY : p < 97 ? OP_SWEEP : OP_NONE;
    x.is_first = $urandom_range(0, 3) == 0;
    return x;
  endfunction

  initial begin
    row_t rows [$];
    in_t x;
    mismatches = 0;
    stim_done = 1'b0;
    push = 1'b0;
    in_i = '0;
    rst_ni = 1'b0;
    for (int i = 0; i < Entries; i++) trk_table[i] = '0;
    for (int i = 0; i < 8; i++) begin
      key_addr[i] = 16'($urandom);
      key_thr[i] = 8'($urandom);
      key_rid[i] = 16'($urandom);
    end
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    x = mk(OP_REPLY, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b0, 16'd0, 16'd0);
    rows.insert(rows.size(), '{x, 1'b1, res(1'b0, x, 32'd0, ST_UNKNOWN)});
    x = mk(OP_PKT, 16'd0, 8'd0, 16'd0, 1'b1, 16'd0, 16'hFFFF);
    rows.insert(rows.size(), '{x, 1'b1, res(1'b1, x, 32'h0000_FFFF, ST_OK)});
    x = mk(OP_PKT, 16'd0, 8'd0, 16'd0, 1'b1, 16'd0, 16'd5);
    rows.insert(rows.size(), '{x, 1'b1, res(1'b0, x, 32'h0000_FFFF, ST_DUP)});
    x = mk(OP_PKT, 16'd0, 8'd0, 16'd0, 1'b0, 16'hFFFF, 16'd1);
    rows.insert(rows.size(), '{x, 1'b0, '0});
    x = mk(OP_PKT, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b0, 16'd7, 16'd10);
    rows.insert(rows.size(), '{x, 1'b0, '0});
    x = mk(OP_PKT, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b1, 16'd1, 16'd20);
    rows.insert(rows.size(), '{x, 1'b0, '0});
    x = mk(OP_PKT, 16'hAAAA, 8'h55, 16'h5A5A, 1'b1, 16'hFFFF, 16'hFFFF);
    rows.insert(rows.size(), '{x, 1'b0, '0});
    x = mk(OP_NONE, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF);
    rows.insert(rows.size(), '{x, 1'b1, '0});
    x = mk(OP_REPLY, 16'd0, 8'd0, 16'd0, 1'b0, 16'd0, 16'd0);
    rows.insert(rows.size(), '{x, 1'b0, '0});
    x = mk(OP_SWEEP, 16'd0, 8'd0, 16'd0, 1'b0, 16'd0, 16'd0);
    rows.insert(rows.size(), '{x, 1'b0, '0});
    rows.insert(rows.size(), '{x, 1'b0, '0});
    foreach (rows[i]) send(rows[i].item, rows[i].has_fixed, rows[i].fixed);
    // fill the table past capacity, then drain it with replies and two sweeps
    for (int i = 0; i < Entries + 2; i++) send(mk(OP_PKT, 16'h1000, 8'd1, i[15:0], 1'b0,
                                                   16'd0, 16'd3), 1'b0, '0);
    for (int i = 0; i < Entries + 2; i++) send(mk(OP_REPLY, 16'h1000, 8'd1, i[15:0], 1'b0,
                                                    16'd0, 16'd0), 1'b0, '0);
    x = mk(OP_SWEEP, 16'd0, 8'd0, 16'd0, 1'b0, 16'd0, 16'd0);
    send(x, 1'b0, '0);
    send(x, 1'b0, '0);
    for (int n = 0; n < NumRandom; n++) send(random_item(), 1'b0, '0);
    push <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    int unsigned n;
    pop = 1'b0;
    @(negedge clk_i);
    forever begin
      n = gap_len();
      if (n != 0) begin
        pop <= 1'b0;
        repeat (n) @(negedge clk_i);
      end
      pop <= 1'b1;
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (outcome_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: %p", out_o);
      end else begin
        out_t want;
        want = outcome_q.pop_front();
        if (out_o !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, out_o);
        end
      end
    end
  end

  initial begin
    cycles = 0;
    @(posedge rst_ni);
    while (!(stim_done && outcome_q.size() == 0) && cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    if (cycles >= CycleLimit) begin
      $display("request_reassembly_tracker regression: fail");
    end else begin
      repeat (2 * Entries + 20) @(posedge clk_i);
      if (mismatches == 0) $display("request_reassembly_tracker regression: pass");
      else $display("request_reassembly_tracker regression: fail");
    end
    $finish;
  end

endmodule
